>>> hw/rtl/line_follow_pid_with_speed_ramp_top_macros.svh
// Assertion macros for the line-follow PID controller.
`ifndef LINE_FOLLOW_PID_WITH_SPEED_RAMP_TOP_MACROS_SVH
`define LINE_FOLLOW_PID_WITH_SPEED_RAMP_TOP_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define LFP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define LFP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/lfpid_pkg.sv
// Constants, types and register codes of the line-follow PID controller.
package lfpid_pkg;

    // Field and state widths
    localparam int SampleBits   = 10;
    localparam int GainBits     = 24;
    localparam int GainFracBits = 16;
    localparam int SumBits      = 32;
    localparam int TickBits     = 16;
    localparam int SpeedBits    = 8;
    localparam int CmdBits      = 8;
    localparam int ErrBits      = SampleBits + 1;
    localparam int DiffBits     = SampleBits + 2;

    // Product and accumulator widths (gains are zero-extended by one sign bit)
    localparam int PKpBits = GainBits + 1 + ErrBits;
    localparam int PKiBits = GainBits + 1 + SumBits;
    localparam int PKdBits = GainBits + 1 + DiffBits;
    localparam int AccBits = PKiBits + 2;

    // Configuration port
    localparam int CfgIdxBits  = 3;
    localparam int CfgDataBits = GainBits;

    // Steering limit
    localparam int TurnLimit = 100;

    // Register reset values
    localparam logic [SampleBits-1:0] GrayReset   = SampleBits'(512);
    localparam logic [GainBits-1:0]   KpReset     = GainBits'(121242);
    localparam logic [GainBits-1:0]   KiReset     = GainBits'(852);
    localparam logic [GainBits-1:0]   KdReset     = GainBits'(39322);
    localparam logic [TickBits-1:0]   PeriodReset = TickBits'(10);

    // Register indexes
    typedef enum logic [CfgIdxBits-1:0] {
        CfgGray       = 3'd0,
        CfgKp         = 3'd1,
        CfgKi         = 3'd2,
        CfgKd         = 3'd3,
        CfgRampPeriod = 3'd4
    } t_cfg_idx;

    // Request kinds
    typedef enum logic {
        ReqControl = 1'b0,
        ReqClear   = 1'b1
    } t_req_type;

endpackage

>>> hw/rtl/line_follow_pid_with_speed_ramp_top.sv
// Line-follow PID steering controller with forward-speed ramp, top level.
//
// Channel   Direction  Handshake                 Beat payload
// in        input      i_in_valid / o_in_stall   req_type, light_sample, target_speed
// out       output     o_out_valid / i_out_stall forward_cmd, turn_cmd
// cfg       input      i_cfg_we (write only)     cfg_idx, cfg_data
//
// One beat per cycle in and out while i_out_stall is low; a result passes the stage A, stage B and output registers.
// Error, integral and ramp state update as the beat is taken; the three gain
// multiplies sit in the second stage and the sum, shift and clamp in the third.
// A clear beat updates state only and makes no result.
// i_rst_n is synchronous: it empties the pipe, zeroes state, restores registers.
// A stalled output backs up stage by stage; o_in_stall rises once stage one is held.
`include "line_follow_pid_with_speed_ramp_top_macros.svh"

module line_follow_pid_with_speed_ramp_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_we,
    input  logic [lfpid_pkg::CfgIdxBits-1:0]       i_cfg_idx,
    input  logic [lfpid_pkg::CfgDataBits-1:0]      i_cfg_data,
    // input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_req_type,
    input  logic [lfpid_pkg::SampleBits-1:0]       i_light_sample,
    input  logic signed [lfpid_pkg::SpeedBits-1:0] i_target_speed,
    // output channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [lfpid_pkg::CmdBits-1:0]   o_forward_cmd,
    output logic signed [lfpid_pkg::CmdBits-1:0]   o_turn_cmd
);

    localparam int SW = lfpid_pkg::SumBits;
    localparam int EW = lfpid_pkg::ErrBits;
    localparam int DW = lfpid_pkg::DiffBits;
    localparam int VW = lfpid_pkg::SpeedBits;
    localparam int AW = lfpid_pkg::AccBits;
    localparam int CW = lfpid_pkg::CmdBits;
    localparam int TW = lfpid_pkg::TickBits;

    // Configuration registers
    logic [lfpid_pkg::SampleBits-1:0] r_gray_level;
    logic [lfpid_pkg::GainBits-1:0]   r_kp_gain;
    logic [lfpid_pkg::GainBits-1:0]   r_ki_dt_gain;
    logic [lfpid_pkg::GainBits-1:0]   r_kd_over_dt_gain;
    logic [TW-1:0]                    r_ramp_period;

    // Controller state
    logic signed [SW-1:0] r_error_sum,  n_error_sum;
    logic signed [EW-1:0] r_last_error, n_last_error;
    logic [TW-1:0]        r_ramp_ticks, n_ramp_ticks;
    logic signed [VW-1:0] r_cur_speed,  n_cur_speed;

    // Stage A: error terms
    logic                 r_pa_valid;
    logic signed [EW-1:0] r_pa_err;
    logic signed [SW-1:0] r_pa_sum;
    logic signed [DW-1:0] r_pa_diff;
    logic signed [VW-1:0] r_pa_speed;

    // Stage B: products
    logic                                     r_pb_valid;
    logic signed [lfpid_pkg::PKpBits-1:0]     r_pb_p_kp;
    logic signed [lfpid_pkg::PKiBits-1:0]     r_pb_p_ki;
    logic signed [lfpid_pkg::PKdBits-1:0]     r_pb_p_kd;
    logic signed [VW-1:0]                     r_pb_speed;

    // Output register
    logic                 r_out_valid;
    logic signed [CW-1:0] r_out_forward;
    logic signed [CW-1:0] r_out_turn;

    // Flow control
    logic can_c, can_b, can_a, move_a, move_b, accept, accept_ctl, accept_clr;

    assign can_c      = !r_out_valid || !i_out_stall;
    assign move_b     = r_pb_valid && can_c;
    assign can_b      = !r_pb_valid || can_c;
    assign move_a     = r_pa_valid && can_b;
    assign can_a      = !r_pa_valid || can_b;
    assign o_in_stall = !can_a;
    assign accept     = i_in_valid && can_a;
    assign accept_ctl = accept && (i_req_type == lfpid_pkg::ReqControl);
    assign accept_clr = accept && (i_req_type == lfpid_pkg::ReqClear);

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gray_level      <= lfpid_pkg::GrayReset;
            r_kp_gain         <= lfpid_pkg::KpReset;
            r_ki_dt_gain      <= lfpid_pkg::KiReset;
            r_kd_over_dt_gain <= lfpid_pkg::KdReset;
            r_ramp_period     <= lfpid_pkg::PeriodReset;
        end else if (i_cfg_we) begin
            unique case (lfpid_pkg::t_cfg_idx'(i_cfg_idx))
                lfpid_pkg::CfgGray: begin
                    r_gray_level <= i_cfg_data[lfpid_pkg::SampleBits-1:0];
                end
                lfpid_pkg::CfgKp: begin
                    r_kp_gain <= i_cfg_data[lfpid_pkg::GainBits-1:0];
                end
                lfpid_pkg::CfgKi: begin
                    r_ki_dt_gain <= i_cfg_data[lfpid_pkg::GainBits-1:0];
                end
                lfpid_pkg::CfgKd: begin
                    r_kd_over_dt_gain <= i_cfg_data[lfpid_pkg::GainBits-1:0];
                end
                lfpid_pkg::CfgRampPeriod: begin
                    r_ramp_period <= i_cfg_data[TW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Error, saturating integral and derivative for the incoming beat
    logic                 tgt_pos;
    logic signed [EW-1:0] err_raw, err;
    logic signed [SW:0]   sum_wide;
    logic signed [SW-1:0] sum_sat;
    logic signed [DW-1:0] diff;

    always_comb begin
        tgt_pos  = !i_target_speed[VW-1] && (i_target_speed != '0);
        err_raw  = $signed({1'b0, r_gray_level}) - $signed({1'b0, i_light_sample});
        err      = tgt_pos ? err_raw : -err_raw;
        sum_wide = $signed({r_error_sum[SW-1], r_error_sum}) + (SW+1)'(err);
        if (sum_wide[SW] != sum_wide[SW-1]) begin
            // overflow: pin to the rail on the side of the true sum
            sum_sat = sum_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[SW-1:0];
        end
        diff = DW'(err) - DW'(r_last_error);
    end

    // Forward speed ramp: one unit toward target every ramp_period steps
    logic [TW-1:0]      ticks_inc;
    logic signed [VW:0] cur_w, tgt_w, step_w;

    always_comb begin
        ticks_inc = r_ramp_ticks + TW'(1);
        cur_w     = (VW+1)'(r_cur_speed);
        tgt_w     = (VW+1)'(i_target_speed);
        step_w    = cur_w;
        if (tgt_w >= cur_w) begin
            step_w = cur_w + (VW+1)'(1);
            if (step_w > tgt_w) begin
                step_w = tgt_w;
            end
        end else begin
            step_w = cur_w - (VW+1)'(1);
            if (step_w < tgt_w) begin
                step_w = tgt_w;
            end
        end
    end

    // Next state
    always_comb begin
        n_error_sum  = r_error_sum;
        n_last_error = r_last_error;
        n_ramp_ticks = r_ramp_ticks;
        n_cur_speed  = r_cur_speed;
        if (accept_clr) begin
            n_error_sum  = '0;
            n_last_error = '0;
        end else if (accept_ctl) begin
            n_error_sum  = sum_sat;
            n_last_error = err;
            if (ticks_inc >= r_ramp_period) begin
                n_ramp_ticks = '0;
                n_cur_speed  = step_w[VW-1:0];
            end else begin
                n_ramp_ticks = ticks_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum  <= '0;
            r_last_error <= '0;
            r_ramp_ticks <= '0;
            r_cur_speed  <= '0;
        end else begin
            r_error_sum  <= n_error_sum;
            r_last_error <= n_last_error;
            r_ramp_ticks <= n_ramp_ticks;
            r_cur_speed  <= n_cur_speed;
        end
    end

    // Stage A register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pa_valid <= 1'b0;
        end else if (accept_ctl) begin
            r_pa_valid <= 1'b1;
        end else if (move_a) begin
            r_pa_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_ctl) begin
            r_pa_err   <= err;
            r_pa_sum   <= sum_sat;
            r_pa_diff  <= diff;
            r_pa_speed <= n_cur_speed;
        end
    end

    // Stage B: gain multiplies
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pb_valid <= 1'b0;
        end else if (move_a) begin
            r_pb_valid <= 1'b1;
        end else if (move_b) begin
            r_pb_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move_a) begin
            r_pb_p_kp  <= $signed({1'b0, r_kp_gain}) * r_pa_err;
            r_pb_p_ki  <= $signed({1'b0, r_ki_dt_gain}) * r_pa_sum;
            r_pb_p_kd  <= $signed({1'b0, r_kd_over_dt_gain}) * r_pa_diff;
            r_pb_speed <= r_pa_speed;
        end
    end

    // Stage C: sum, negate, scale toward zero and clamp
    logic signed [AW-1:0] acc;
    logic [AW-1:0]        mag, quo;
    logic [CW-1:0]        quo_clamp;
    logic signed [CW-1:0] turn;

    always_comb begin
        acc = AW'(r_pb_p_kp) + AW'(r_pb_p_ki) + AW'(r_pb_p_kd);
        mag = acc[AW-1] ? AW'(-acc) : AW'(acc);
        quo = mag >> lfpid_pkg::GainFracBits;
        if (quo > AW'(lfpid_pkg::TurnLimit)) begin
            quo_clamp = CW'(lfpid_pkg::TurnLimit);
        end else begin
            quo_clamp = quo[CW-1:0];
        end
        // turn is the negated PID sum
        turn = (!acc[AW-1] && (acc != '0)) ? -$signed(quo_clamp) : $signed(quo_clamp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move_b) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move_b) begin
            r_out_forward <= r_pb_speed;
            r_out_turn    <= turn;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_forward_cmd = r_out_forward;
    assign o_turn_cmd    = r_out_turn;

    // Checks
    `LFP_ASSERT_NXT(a_clear_zeroes, accept_clr, (r_error_sum == '0) && (r_last_error == '0), "clear beat left PID state")
    `LFP_ASSERT_IMP(a_stall_cause, o_in_stall, r_pa_valid && r_pb_valid && r_out_valid, "input stall without full pipe")
    `LFP_ASSERT_IMP(a_turn_range, o_out_valid, ($signed(o_turn_cmd) <= lfpid_pkg::TurnLimit) && ($signed(o_turn_cmd) >= -lfpid_pkg::TurnLimit), "turn command out of range")

endmodule

>>> bench/line_follow_pid_with_speed_ramp_top_test.sv
// Self-checking testbench for the line-follow PID steering controller with speed ramp.
`timescale 1ns / 1ps

module line_follow_pid_with_speed_ramp_top_test;

    // Local widths taken from the package
    localparam int IdxW  = lfpid_pkg::CfgIdxBits;
    localparam int DataW = lfpid_pkg::CfgDataBits;
    localparam int SampW = lfpid_pkg::SampleBits;
    localparam int SpdW  = lfpid_pkg::SpeedBits;
    localparam int CmdW  = lfpid_pkg::CmdBits;

    // Spare register index that the block must ignore
    localparam logic [IdxW-1:0] CfgSpare = '1;
    localparam int DirRows     = 21;
    localparam int HoldCycles  = 400;
    localparam int SettleTicks = 8;

    // One result beat
    typedef struct packed {
        logic signed [CmdW-1:0] fwd;
        logic signed [CmdW-1:0] turn;
    } t_drive_cmd;

    // One row of the directed table; typed rows carry their own result
    typedef struct packed {
        lfpid_pkg::t_req_type   req;
        logic [SampW-1:0]       sample;
        logic signed [SpdW-1:0] target;
        bit                     typed;
        logic signed [CmdW-1:0] fwd;
        logic signed [CmdW-1:0] turn;
    } t_steer_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [IdxW-1:0]               i_cfg_idx = '0;
    logic [DataW-1:0]              i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic                          i_req_type = lfpid_pkg::ReqControl;
    logic [SampW-1:0]              i_light_sample = '0;
    logic signed [SpdW-1:0]        i_target_speed = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic signed [CmdW-1:0]        o_forward_cmd;
    logic signed [CmdW-1:0]        o_turn_cmd;

    // Predictor copy of registers and state
    int gray_cfg, kp_cfg, ki_cfg, kd_cfg, period_cfg;
    int err_sum, prev_err, tick_count, speed_now;

    t_drive_cmd pending_cmds [$];
    int  mismatch_count = 0;
    bit  steady = 1'b0;
    int  hold_requests = 0;
    int  hold_served = 0;
    int  hold_left = 0;
    int  stall_left = 0;
    int  cruise_target = 0;

    t_steer_row dir_rows [DirRows] = '{
        '{lfpid_pkg::ReqControl, 10'd512,  8'sd0,    1'b1, 8'sd0, 8'sd0},
        '{lfpid_pkg::ReqClear,   10'd1023, 8'sd100,  1'b0, 8'sd0, 8'sd0},
        '{lfpid_pkg::ReqControl, 10'd0,    8'sd100,  1'b1, 8'sd0, -8'sd100},
        '{lfpid_pkg::ReqControl, 10'd1023, 8'sd100,  1'b1, 8'sd0, 8'sd100},
        '{lfpid_pkg::ReqClear,   10'd0,    -8'sd128, 1'b0, 8'sd0, 8'sd0},
        '{lfpid_pkg::ReqControl, 10'd1023, -8'sd100, 1'b0, 8'sd0, 8'sd0},
        '{lfpid_pkg::ReqControl, 10'd0,    -8'sd128, 1'b0, 8'sd0, 8'sd0},
        '{lfpid_pkg::ReqControl, 10'd512,  8'sd127,  1'b0, 8'sd0, 8'sd0},
        '{lfpid_pkg::ReqControl, 10'd0,    8'sd1,    1'b0, 8'sd0, 8'sd0},
        '{lfpid_pkg::ReqControl, 10'd1023, 8'sd0,    1'b0, 8'sd0, 8'sd0},
        '{lfpid_pkg::ReqControl, 10'd511,  8'sd100,  1'b0, 8'sd0, 8'sd0},
        '{lfpid_pkg::ReqControl, 10'd513,  -8'sd1,   1'b0, 8'sd0, 8'sd0},
        '{lfpid_pkg::ReqControl, 10'd0,    8'sd100,  1'b0, 8'sd0, 8'sd0},
        '{lfpid_pkg::ReqControl, 10'd0,    8'sd100,  1'b0, 8'sd0, 8'sd0},
        '{lfpid_pkg::ReqControl, 10'd1023, -8'sd100, 1'b0, 8'sd0, 8'sd0},
        '{lfpid_pkg::ReqClear,   10'd512,  8'sd0,    1'b0, 8'sd0, 8'sd0},
        '{lfpid_pkg::ReqControl, 10'd1023, 8'sd0,    1'b0, 8'sd0, 8'sd0},
        '{lfpid_pkg::ReqControl, 10'd600,  8'sd50,   1'b0, 8'sd0, 8'sd0},
        '{lfpid_pkg::ReqControl, 10'd400,  8'sd50,   1'b0, 8'sd0, 8'sd0},
        '{lfpid_pkg::ReqControl, 10'd512,  8'sd50,   1'b0, 8'sd0, 8'sd0},
        '{lfpid_pkg::ReqControl, 10'd700,  8'sd50,   1'b0, 8'sd0, 8'sd0}
    };

    line_follow_pid_with_speed_ramp_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_light_sample (i_light_sample),
        .i_target_speed (i_target_speed),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_forward_cmd  (o_forward_cmd),
        .o_turn_cmd     (o_turn_cmd)
    );

    // 12 ns clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Hang guard
    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_idle(input int none_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < none_pct) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 50);
    endfunction

    // Steering predictor: updates state for one accepted beat, returns 1 if it makes a result
    function automatic bit predict_steer(input lfpid_pkg::t_req_type kind,
                                         input logic [SampW-1:0] sample,
                                         input logic signed [SpdW-1:0] target,
                                         output t_drive_cmd cmd);
        int     tgt, e, d;
        longint sum_next, acc, neg, mag, q;
        cmd = '0;
        if (kind == lfpid_pkg::ReqClear) begin
            err_sum  = 0;
            prev_err = 0;
            return 1'b0;
        end
        tgt = target;
        // speed ramp: one unit toward target every period steps
        tick_count = (tick_count + 1) & 16'hFFFF;
        if (tick_count >= period_cfg) begin
            if (tgt - speed_now >= 0) speed_now = (speed_now + 1 > tgt) ? tgt : speed_now + 1;
            else speed_now = (speed_now - 1 < tgt) ? tgt : speed_now - 1;
            tick_count = 0;
        end
        e = (tgt > 0) ? gray_cfg - int'(sample) : int'(sample) - gray_cfg;
        sum_next = longint'(err_sum) + e;
        if (sum_next > 64'sh7FFF_FFFF) err_sum = 32'sh7FFF_FFFF;
        else if (sum_next < -64'sh8000_0000) err_sum = 32'sh8000_0000;
        else err_sum = int'(sum_next);
        d = e - prev_err;
        prev_err = e;
        acc = longint'(kp_cfg) * e + longint'(ki_cfg) * err_sum + longint'(kd_cfg) * d;
        neg = -acc;
        mag = (neg < 0) ? -neg : neg;
        q = mag >>> lfpid_pkg::GainFracBits;
        if (q > lfpid_pkg::TurnLimit) q = lfpid_pkg::TurnLimit;
        cmd.fwd  = CmdW'(speed_now);
        cmd.turn = CmdW'((neg < 0) ? -q : q);
        return 1'b1;
    endfunction

    task automatic report_miss(input string what, input t_drive_cmd want, input t_drive_cmd got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected fwd %0d turn %0d, got fwd %0d turn %0d",
                     $realtime, what, want.fwd, want.turn, got.fwd, got.turn);
    endtask

    // Offer one beat, wait for it to be taken, then maybe go idle
    task automatic send_beat(input lfpid_pkg::t_req_type kind, input logic [SampW-1:0] sample,
                             input logic signed [SpdW-1:0] target,
                             input bit typed, input t_drive_cmd typed_cmd);
        t_drive_cmd cmd;
        int gap;
        i_in_valid     <= 1'b1;
        i_req_type     <= kind;
        i_light_sample <= sample;
        i_target_speed <= target;
        do @(posedge i_clk); while (o_in_stall);
        if (predict_steer(kind, sample, target, cmd))
            pending_cmds.push_back(typed ? typed_cmd : cmd);
        gap = steady ? 0 : pick_idle(55);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering, wait for every result, then let the block settle
    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (SettleTicks) @(posedge i_clk);
    endtask

    // Rewrite all registers while idle, plus the spare index that must be ignored
    task automatic load_regs(input int gray, input int kp, input int ki, input int kd,
                             input int period);
        logic [IdxW-1:0]  idx_list [6];
        logic [DataW-1:0] data_list [6];
        drain_pipe();
        idx_list  = '{lfpid_pkg::CfgGray, lfpid_pkg::CfgKp, lfpid_pkg::CfgKi,
                      lfpid_pkg::CfgKd, lfpid_pkg::CfgRampPeriod, CfgSpare};
        data_list = '{DataW'(gray), DataW'(kp), DataW'(ki),
                      DataW'(kd), DataW'(period), '1};
        i_cfg_we <= 1'b1;
        for (int k = 0; k < 6; k++) begin
            i_cfg_idx  <= idx_list[k];
            i_cfg_data <= data_list[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        gray_cfg   = gray & 10'h3FF;
        kp_cfg     = kp & 24'hFFFFFF;
        ki_cfg     = ki & 24'hFFFFFF;
        kd_cfg     = kd & 24'hFFFFFF;
        period_cfg = period & 16'hFFFF;
    endtask

    // Random beats: cruising target held for runs, samples mostly near the line
    task automatic random_beats(input int count);
        lfpid_pkg::t_req_type   kind;
        int                     s;
        logic signed [SpdW-1:0] tgt;
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0 && hold_served == hold_requests) steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 19) == 0) begin
                if ($urandom_range(0, 9) < 7) cruise_target = int'($urandom_range(0, 200)) - 100;
                else cruise_target = int'($urandom_range(0, 255)) - 128;
            end
            kind = ($urandom_range(0, 99) < 4) ? lfpid_pkg::ReqClear : lfpid_pkg::ReqControl;
            if ($urandom_range(0, 9) < 7) begin
                s = gray_cfg + int'($urandom_range(0, 120)) - 60;
                if (s < 0) s = 0;
                if (s > 1023) s = 1023;
            end else begin
                s = $urandom_range(0, 1023);
            end
            tgt = ($urandom_range(0, 29) == 0) ? SpdW'($urandom_range(0, 255))
                                               : SpdW'(cruise_target);
            send_beat(kind, SampW'(s), tgt, 1'b0, '0);
        end
    endtask

    // Result side: check each taken beat, then choose the next stall
    always @(posedge i_clk) begin
        t_drive_cmd got, want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got.fwd  = o_forward_cmd;
                got.turn = o_turn_cmd;
                if (pending_cmds.size() == 0) begin
                    report_miss("unexpected result", '0, got);
                end else begin
                    want = pending_cmds.pop_front();
                    if (got.fwd !== want.fwd) report_miss("forward_cmd mismatch", want, got);
                    if (got.turn !== want.turn) report_miss("turn_cmd mismatch", want, got);
                end
            end
            if (hold_served != hold_requests) begin
                hold_left = HoldCycles;
                hold_served++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (steady) begin
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 99) < 20) begin
                stall_left = pick_idle(0) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        t_drive_cmd typed_cmd;
        gray_cfg   = lfpid_pkg::GrayReset;
        kp_cfg     = lfpid_pkg::KpReset;
        ki_cfg     = lfpid_pkg::KiReset;
        kd_cfg     = lfpid_pkg::KdReset;
        period_cfg = lfpid_pkg::PeriodReset;
        err_sum    = 0;
        prev_err   = 0;
        tick_count = 0;
        speed_now  = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows under reset registers
        for (int i = 0; i < DirRows; i++) begin
            typed_cmd.fwd  = dir_rows[i].fwd;
            typed_cmd.turn = dir_rows[i].turn;
            send_beat(dir_rows[i].req, dir_rows[i].sample, dir_rows[i].target,
                      dir_rows[i].typed, typed_cmd);
        end
        random_beats(200);

        // extremes: full gains with ramp every step, then zero gains with slowest ramp
        load_regs(0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1);
        random_beats(150);
        load_regs(1023, 0, 0, 0, 16'hFFFF);
        random_beats(100);

        // period zero ramps on every step
        load_regs($urandom_range(0, 1023), $urandom_range(0, 300000),
                  $urandom_range(0, 5000), $urandom_range(0, 100000), 0);
        random_beats(150);

        // receiver holds off long while the sender keeps offering beats back to back
        load_regs(lfpid_pkg::GrayReset, lfpid_pkg::KpReset, lfpid_pkg::KiReset,
                  lfpid_pkg::KdReset, 3);
        steady = 1'b1;
        hold_requests++;
        random_beats(200);
        steady = 1'b0;

        // assorted settings
        for (int p = 0; p < 4; p++) begin
            load_regs($urandom_range(0, 1023), $urandom_range(0, 400000),
                      $urandom_range(0, 8000), $urandom_range(0, 200000),
                      $urandom_range(1, 20));
            random_beats(200);
        end

        drain_pipe();
        if (mismatch_count == 0 && pending_cmds.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
